// ===== rtl/core/abhv_pkg.sv =====
// ----------------------------------------------------------------------------
// abhv_pkg
// types and constants shared by the archive block header validator
// ----------------------------------------------------------------------------
package abhv_pkg;

    localparam int OffsetBits = 40;
    localparam int CountBits = 18;
    localparam logic [CountBits-1:0] MaxMembers = 18'd200000;

    localparam logic [15:0] Version = 16'h0200;
    localparam logic [15:0] ArchHdrSize = 16'd14;
    localparam logic [15:0] FixedHdrSize = 16'd45;
    localparam logic [31:0] FlagMask = 32'h0000_003b;

    typedef enum logic [2:0] {
        PH_ARCH   = 3'd0,
        PH_PREFIX = 3'd1,
        PH_NAME   = 3'd2,
        PH_TAIL   = 3'd3,
        PH_DATA   = 3'd4,
        PH_DRAIN  = 3'd5
    } phase_t;

    typedef enum logic [3:0] {
        E_OK       = 4'd0,
        E_ARCH     = 4'd1,
        E_VOL      = 4'd2,
        E_MAGIC    = 4'd3,
        E_SIZES    = 4'd4,
        E_FLAGS    = 4'd5,
        E_NAME     = 4'd6,
        E_MISMATCH = 4'd7,
        E_TRUNC    = 4'd8,
        E_EMPTY    = 4'd9,
        E_MANY     = 4'd10
    } err_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic                  record_kind;
        logic [3:0]            error_code;
        logic [OffsetBits-1:0] hdr_pos;
        logic [5:0]            member_flags;
        logic [31:0]           vol_bytes;
        logic [31:0]           full_len;
        logic [31:0]           pack_len;
        logic [31:0]           attributes;
        logic [31:0]           file_stamp;
        logic [31:0]           packed_crc;
        logic [3:0]            vol_flag;
        logic [15:0]           disk_id;
    } out_item_t;

    // what the parser hands to the output stage for one byte
    typedef struct packed {
        logic      rec_valid;
        out_item_t rec;
        logic      ver_valid;
        out_item_t ver;
    } step_res_t;

    function automatic logic [7:0] arch_magic(input logic [1:0] i);
        case (i)
            2'd0: arch_magic = 8'h41;
            2'd1: arch_magic = 8'h52;
            2'd2: arch_magic = 8'h43;
            default: arch_magic = 8'h56;
        endcase
    endfunction

    function automatic logic [7:0] blck_magic(input logic [1:0] i);
        case (i)
            2'd0: blck_magic = 8'h42;
            2'd1: blck_magic = 8'h4c;
            2'd2: blck_magic = 8'h43;
            default: blck_magic = 8'h4b;
        endcase
    endfunction

endpackage

// ===== rtl/core/abhv_parser.sv =====
// ----------------------------------------------------------------------------
// abhv_parser
// byte-wide header parser: updates parse state on each transfer and forms
// the record and verdict items caused by that byte
// ----------------------------------------------------------------------------
module abhv_parser
    import abhv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  in_item_t              item,
    input  logic [OffsetBits-1:0] base,
    output step_res_t             res
);

    phase_t                phase_reg, phase_next;
    logic [8:0]            bih_reg, bih_next;
    logic [31:0]           shift_reg, shift_next;
    logic [7:0]            nlen_reg, nlen_next;
    logic [15:0]           hlen_reg, hlen_next;
    logic [5:0]            cflags_reg, cflags_next;
    logic [31:0]           flagw_reg, flagw_next;
    logic [31:0]           fld_reg [6];
    logic [31:0]           fld_next [6];
    logic [31:0]           left_reg, left_next;
    logic [OffsetBits-1:0] pos_reg, pos_next;
    logic [OffsetBits-1:0] bstart_reg, bstart_next;
    logic [CountBits-1:0]  count_reg, count_next;
    err_t                  err_reg, err_next;
    logic [3:0]            vol_reg, vol_next;
    logic [15:0]           disk_reg, disk_next;

    logic [7:0]  b;
    logic [31:0] acc;
    logic [1:0]  k;
    logic        rec;
    logic [31:0] fw;
    logic [5:0]  method, span;
    logic        split, stored, packed_m;
    err_t        code;

    always_comb
    begin
        b = item.data_byte;
        phase_next = phase_reg;
        bih_next = bih_reg;
        nlen_next = nlen_reg;
        hlen_next = hlen_reg;
        cflags_next = cflags_reg;
        flagw_next = flagw_reg;
        for (int j = 0; j < 6; j++)
        begin
            fld_next[j] = fld_reg[j];
        end
        left_next = left_reg;
        pos_next = pos_reg + OffsetBits'(1);
        bstart_next = bstart_reg;
        count_next = count_reg;
        err_next = err_reg;
        vol_next = vol_reg;
        disk_next = disk_reg;
        rec = 1'b0;
        k = 2'd0;
        acc = shift_reg;
        fw = flagw_reg;
        method = 6'd0;
        span = 6'd0;
        split = 1'b0;
        stored = 1'b0;
        packed_m = 1'b0;

        case (phase_reg)
            PH_ARCH:
            begin
                if (bih_reg < 9'd4)
                begin
                    if (b != arch_magic(bih_reg[1:0]))
                    begin
                        err_next = E_ARCH;
                        phase_next = PH_DRAIN;
                    end
                    else
                    begin
                        bih_next = bih_reg + 9'd1;
                    end
                end
                else
                begin
                    if (bih_reg < 9'd8)
                    begin
                        k = {1'b0, bih_reg[0]};
                    end
                    else
                    begin
                        k = 2'(bih_reg - 9'd8);
                    end
                    acc = (k == 2'd0) ? {24'd0, b} : (shift_reg | ({24'd0, b} << (8 * k)));
                    bih_next = bih_reg + 9'd1;
                    if ((bih_reg == 9'd5 && acc != 32'(Version))
                        || (bih_reg == 9'd7 && acc != 32'(ArchHdrSize)))
                    begin
                        err_next = E_ARCH;
                        phase_next = PH_DRAIN;
                    end
                    else if (bih_reg == 9'd11)
                    begin
                        if (acc != 32'd1 && acc != 32'd2 && acc != 32'd4 && acc != 32'd8)
                        begin
                            err_next = E_VOL;
                            phase_next = PH_DRAIN;
                        end
                        else
                        begin
                            vol_next = acc[3:0];
                        end
                    end
                    else if (bih_reg == 9'd13)
                    begin
                        disk_next = acc[15:0];
                        phase_next = PH_PREFIX;
                        bih_next = 9'd0;
                    end
                end
            end
            PH_PREFIX:
            begin
                if (bih_reg == 9'd0 && count_reg >= MaxMembers)
                begin
                    err_next = E_MANY;
                    phase_next = PH_DRAIN;
                end
                else if (bih_reg < 9'd4)
                begin
                    if (bih_reg == 9'd0)
                    begin
                        bstart_next = pos_reg;
                    end
                    if (b != blck_magic(bih_reg[1:0]))
                    begin
                        err_next = E_MAGIC;
                        phase_next = PH_DRAIN;
                    end
                    else
                    begin
                        bih_next = bih_reg + 9'd1;
                    end
                end
                else if (bih_reg < 9'd16)
                begin
                    k = (bih_reg < 9'd6) ? 2'(bih_reg - 9'd4) :
                        (bih_reg < 9'd8) ? 2'(bih_reg - 9'd6) : bih_reg[1:0];
                    acc = (k == 2'd0) ? {24'd0, b} : (shift_reg | ({24'd0, b} << (8 * k)));
                    bih_next = bih_reg + 9'd1;
                    if (bih_reg == 9'd5 && acc != 32'(Version))
                    begin
                        err_next = E_MAGIC;
                        phase_next = PH_DRAIN;
                    end
                    if (bih_reg == 9'd7)
                    begin
                        hlen_next = acc[15:0];
                    end
                    if (bih_reg == 9'd11)
                    begin
                        flagw_next = acc;
                    end
                    if (bih_reg == 9'd15)
                    begin
                        fld_next[0] = acc;
                    end
                end
                else
                begin
                    nlen_next = b;
                    method = fw[5:0] & 6'h30;
                    span = fw[5:0] & 6'h0b;
                    if (b == 8'd0 || hlen_reg != FixedHdrSize + {8'd0, b})
                    begin
                        err_next = E_SIZES;
                        phase_next = PH_DRAIN;
                    end
                    else if ((fw & ~FlagMask) != 32'd0
                             || !(method == 6'h10 || method == 6'h20)
                             || !(span == 6'h01 || span == 6'h02 || span == 6'h08))
                    begin
                        err_next = E_FLAGS;
                        phase_next = PH_DRAIN;
                    end
                    else
                    begin
                        cflags_next = fw[5:0];
                        phase_next = PH_NAME;
                        bih_next = 9'd0;
                    end
                end
            end
            PH_NAME:
            begin
                if (b < 8'h20 || b > 8'h7e)
                begin
                    err_next = E_NAME;
                    phase_next = PH_DRAIN;
                end
                else if (bih_reg + 9'd1 >= {1'b0, nlen_reg})
                begin
                    phase_next = PH_TAIL;
                    bih_next = 9'd0;
                end
                else
                begin
                    bih_next = bih_reg + 9'd1;
                end
            end
            PH_TAIL:
            begin
                k = bih_reg[1:0];
                if (bih_reg < 9'd16 || bih_reg >= 9'd24)
                begin
                    acc = (k == 2'd0) ? {24'd0, b} : (shift_reg | ({24'd0, b} << (8 * k)));
                end
                if (bih_reg < 9'd16 && k == 2'd3)
                begin
                    fld_next[3'd1 + 3'(bih_reg[3:2])] = acc;
                end
                if (bih_reg < 9'd27)
                begin
                    bih_next = bih_reg + 9'd1;
                end
                else
                begin
                    fld_next[5] = acc;
                    split = (cflags_reg & 6'h0a) != 6'd0;
                    stored = cflags_reg[4];
                    packed_m = cflags_reg[5];
                    if (!split && (fld_reg[2] != fld_reg[0]
                                   || (stored && fld_reg[1] != fld_reg[0])
                                   || (packed_m && fld_reg[1] == 32'd0)))
                    begin
                        err_next = E_MISMATCH;
                        phase_next = PH_DRAIN;
                    end
                    else
                    begin
                        rec = 1'b1;
                        count_next = count_reg + CountBits'(1);
                        left_next = fld_reg[0];
                        phase_next = (fld_reg[0] != 32'd0) ? PH_DATA : PH_PREFIX;
                        bih_next = 9'd0;
                    end
                end
            end
            PH_DATA:
            begin
                left_next = left_reg - 32'd1;
                if (left_next == 32'd0)
                begin
                    phase_next = PH_PREFIX;
                    bih_next = 9'd0;
                end
            end
            default:
            begin
            end
        endcase
        shift_next = acc;

        if (err_next != E_OK)
        begin
            code = err_next;
        end
        else if (phase_next != PH_PREFIX || bih_next != 9'd0)
        begin
            code = E_TRUNC;
        end
        else if (count_next == '0)
        begin
            code = E_EMPTY;
        end
        else
        begin
            code = E_OK;
        end

        res = '0;
        res.rec_valid = rec;
        res.rec.hdr_pos = base + bstart_reg;
        res.rec.member_flags = cflags_reg;
        res.rec.vol_bytes = fld_reg[0];
        res.rec.full_len = fld_reg[1];
        res.rec.pack_len = fld_reg[2];
        res.rec.attributes = fld_reg[3];
        res.rec.file_stamp = fld_reg[4];
        res.rec.packed_crc = acc;
        res.ver_valid = item.final_byte;
        res.ver.record_kind = 1'b1;
        res.ver.error_code = code;
        res.ver.hdr_pos = pos_next;
        if (code == E_OK)
        begin
            res.ver.vol_flag = vol_next;
            res.ver.disk_id = disk_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ARCH;
            bih_reg <= '0;
            shift_reg <= '0;
            nlen_reg <= '0;
            hlen_reg <= '0;
            cflags_reg <= '0;
            flagw_reg <= '0;
            left_reg <= '0;
            pos_reg <= '0;
            bstart_reg <= '0;
            count_reg <= '0;
            err_reg <= E_OK;
            vol_reg <= '0;
            disk_reg <= '0;
        end
        else if (step)
        begin
            if (item.final_byte)
            begin
                phase_reg <= PH_ARCH;
                bih_reg <= '0;
                shift_reg <= '0;
                nlen_reg <= '0;
                hlen_reg <= '0;
                cflags_reg <= '0;
                flagw_reg <= '0;
                left_reg <= '0;
                pos_reg <= '0;
                bstart_reg <= '0;
                count_reg <= '0;
                err_reg <= E_OK;
                vol_reg <= '0;
                disk_reg <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                bih_reg <= bih_next;
                shift_reg <= shift_next;
                nlen_reg <= nlen_next;
                hlen_reg <= hlen_next;
                cflags_reg <= cflags_next;
                flagw_reg <= flagw_next;
                left_reg <= left_next;
                pos_reg <= pos_next;
                bstart_reg <= bstart_next;
                count_reg <= count_next;
                err_reg <= err_next;
                vol_reg <= vol_next;
                disk_reg <= disk_next;
            end
        end
    end

    // member fields are payload, no reset
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int j = 0; j < 6; j++)
            begin
                fld_reg[j] <= fld_next[j];
            end
        end
    end

    a_drain_has_error: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DRAIN |-> err_reg != E_OK)
        else $error("drain without latched error");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MaxMembers)
        else $error("member count beyond limit");
    a_rec_in_tail: assert property (@(posedge clk) disable iff (!rst_n)
        res.rec_valid |-> phase_reg == PH_TAIL && bih_reg == 9'd27)
        else $error("record outside tail end");

endmodule

// ===== rtl/core/abhv_out_queue.sv =====
// ----------------------------------------------------------------------------
// abhv_out_queue
// four-entry result queue; a byte may add up to two items at once
// ----------------------------------------------------------------------------
module abhv_out_queue
    import abhv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  step_res_t res,
    output logic      has_room,
    output logic      valid,
    input  logic      ready,
    output out_item_t data
);

    out_item_t  mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       pop;
    logic [2:0] nin;

    assign pop = valid && ready;
    assign valid = cnt_reg != 3'd0;
    assign data = mem_reg[rp_reg];
    // room for two more items after this cycle's pop is not counted
    assign has_room = cnt_reg <= 3'd2;
    assign nin = push ? (3'(res.rec_valid) + 3'(res.ver_valid)) : 3'd0;

    always_ff @(posedge clk)
    begin
        if (push && res.rec_valid)
        begin
            mem_reg[wp_reg] <= res.rec;
        end
        if (push && res.ver_valid)
        begin
            mem_reg[wp_reg + 2'(res.rec_valid)] <= res.ver;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_reg + nin[1:0];
            rp_reg <= rp_reg + 2'(pop);
            cnt_reg <= cnt_reg + nin - 3'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("result queue overflow");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> has_room)
        else $error("push without room");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        !push && !pop |=> $stable(cnt_reg))
        else $error("count moved while idle");

endmodule

// ===== rtl/core/archive_block_header_validator_top.sv =====
// ----------------------------------------------------------------------------
// archive_block_header_validator_top
// streaming header checker for ARCV 2.00 archives
// ----------------------------------------------------------------------------
// in channel: one archive byte per transfer, final_byte marks the last byte.
// out channel: one member record after each good member header, one verdict
// on the last byte (record first when both fall on the same byte).
// cfg channel: archive_base, added to every record offset; write when idle.
// a byte is parsed in the cycle it is accepted; its results are registered
// in a four-entry queue that feeds the out channel.
// throughput is one byte per cycle while the receiver keeps up; in_ready
// drops only when the queue holds three or more results.
// reset clears the parse state, the queue and archive_base. a stalled
// receiver fills the queue, then holds off input until results drain.
// after a verdict the parser starts a fresh archive on the next byte.
// ----------------------------------------------------------------------------
module archive_block_header_validator_top
    import abhv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [OffsetBits-1:0] cfg_data
);

    logic [OffsetBits-1:0] base_reg;
    step_res_t             res;
    logic                  step;

    assign cfg_ready = 1'b1;
    assign step = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_valid)
        begin
            base_reg <= cfg_data;
        end
    end

    abhv_parser u_parser (
        .clk  (clk),
        .rst_n(rst_n),
        .step (step),
        .item (in_data),
        .base (base_reg),
        .res  (res)
    );

    abhv_out_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (step),
        .res     (res),
        .has_room(in_ready),
        .valid   (out_valid),
        .ready   (out_ready),
        .data    (out_data)
    );

endmodule
